[sv/qau_pkg.sv]
`default_nettype none
package qau_pkg;

  // Word format
  localparam int WORD_W    = 32;
  localparam int FRAC_BITS = 16;
  localparam int NORM_W    = WORD_W + 1;
  localparam int PROD_W    = 2 * WORD_W;
  // Sum of four squares
  localparam int SQ_W      = PROD_W + 1;

  // Square root: one root bit per stage
  localparam int SQRT_STAGES = NORM_W;
  localparam int RAD_W       = 2 * SQRT_STAGES;
  localparam int REM_W       = NORM_W + 3;

  // Divider: one quotient bit per stage
  localparam int DNUM_W = 2 * WORD_W;
  localparam int DDEN_W = SQ_W;
  localparam int DREM_W = DDEN_W + 1;

  // Hamilton product sums and saturation input
  localparam int HSUM_W = PROD_W + 2;
  localparam int SAT_W  = HSUM_W + 1;

  // Squares, sum, root, setup, divide, saturate, two product stages, output
  localparam int LATENCY = 2 + SQRT_STAGES + 1 + DNUM_W + 1 + 2 + 1;

  // Opcodes
  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_MUL   = 4'd2;
  localparam logic [3:0] OP_SCALE = 4'd3;
  localparam logic [3:0] OP_CONJ  = 4'd4;
  localparam logic [3:0] OP_MAG   = 4'd5;
  localparam logic [3:0] OP_NORM  = 4'd6;
  localparam logic [3:0] OP_INV   = 4'd7;
  localparam logic [3:0] OP_DIV   = 4'd8;

  // Status codes
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DZ  = 2'd1;
  localparam logic [1:0] ST_OVF = 2'd2;

  localparam logic signed [SAT_W-1:0] SMAX_W =
    {{(SAT_W - WORD_W + 1){1'b0}}, {(WORD_W - 1){1'b1}}};
  localparam logic signed [SAT_W-1:0] SMIN_W =
    {{(SAT_W - WORD_W + 1){1'b1}}, {(WORD_W - 1){1'b0}}};

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [HSUM_W-1:0] hsum_t;

  typedef struct packed {
    word_t w;
    word_t x;
    word_t y;
    word_t z;
  } quat_t;

  typedef struct packed {
    hsum_t w;
    hsum_t x;
    hsum_t y;
    hsum_t z;
  } hquat_t;

  typedef struct packed {
    logic [3:0] req_type;
    word_t      a_w;
    word_t      a_x;
    word_t      a_y;
    word_t      a_z;
    word_t      b_w;
    word_t      b_x;
    word_t      b_y;
    word_t      b_z;
    word_t      scale_factor;
  } req_t;

  typedef struct packed {
    word_t             res_w;
    word_t             res_x;
    word_t             res_y;
    word_t             res_z;
    logic [NORM_W-1:0] norm_value;
    logic [1:0]        status;
  } res_t;

  typedef struct packed {
    word_t v;
    logic  ovf;
  } sat_t;

  // Clamp a wide signed value to the word range
  function automatic sat_t saturate(input logic signed [SAT_W-1:0] v);
    sat_t r;
    if (v > SMAX_W) begin
      r.v   = {1'b0, {(WORD_W - 1){1'b1}}};
      r.ovf = 1'b1;
    end else if (v < SMIN_W) begin
      r.v   = {1'b1, {(WORD_W - 1){1'b0}}};
      r.ovf = 1'b1;
    end else begin
      r.v   = v[WORD_W-1:0];
      r.ovf = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/quaternion_arithmetic_unit.sv]
`default_nettype none
// Quaternion arithmetic unit, signed Q16.16 components.
// Request: raise start with req (opcode, quaternions a and b, scale
// factor); the transfer happens on any edge with start high and busy low.
// busy is high only during reset, so a request can enter every cycle.
// Result: done is high for one cycle with res (four components, magnitude
// of a, status); the receiver takes it in that cycle and cannot stall.
// Every opcode takes the same path: a squaring stage, a summing stage,
// 33 root stages (one root bit each), a setup stage,
// 64 divider stages (one quotient bit each, four lanes), a saturation stage,
// two Hamilton product stages and the output register.
// Throughput is one request per cycle; results leave in request order.
// Reset clears every valid bit; requests in flight are dropped and no
// result is produced for them.
module quaternion_arithmetic_unit (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  output logic                 busy,
  input  wire qau_pkg::req_t   req,
  output logic                 done,
  output qau_pkg::res_t        res
);
  import qau_pkg::*;

  typedef struct packed {
    req_t            req;
    logic [SQ_W-1:0] den_sq;
    logic            den_zero;
  } sb_sq_t;

  typedef struct packed {
    req_t              req;
    logic [NORM_W-1:0] mag;
    logic              dz;
    logic [3:0]        neg;
  } sb_dv_t;

  typedef struct packed {
    req_t              req;
    logic [NORM_W-1:0] mag;
    logic              dz;
    quat_t             inv;
    logic              ovf;
  } sb_hp_t;

  logic              accept;
  logic [LATENCY-1:0] vld;

  logic [PROD_W-1:0] sq_a [4];
  logic [PROD_W-1:0] sq_b [4];
  req_t              req1;
  logic [SQ_W-1:0]   sum_a;
  logic [SQ_W-1:0]   sum_b;
  logic [SQ_W-1:0]   den_sel;
  sb_sq_t            sb2;
  logic [SQ_W-1:0]   rad_a;
  sb_sq_t            sb_sq [SQRT_STAGES];
  logic [NORM_W-1:0] root;

  word_t             av [4];
  word_t             bv [4];
  logic [DNUM_W-1:0] num [4];
  logic [DNUM_W-1:0] num_next [4];
  logic [DDEN_W-1:0] den;
  logic [DDEN_W-1:0] den_next;
  sb_dv_t            sb_set;
  sb_dv_t            sb_set_next;
  sb_dv_t            sb_dv [DNUM_W];
  logic [DNUM_W-1:0] quo [4];

  sb_hp_t            sb_s;
  sb_hp_t            sb_s_next;
  sb_hp_t            sb_h1;
  sb_hp_t            sb_h2;
  quat_t             hq;
  hquat_t            ht;
  res_t              res_next;

  function automatic logic [DNUM_W-1:0] abs_word(input word_t v);
    logic signed [WORD_W:0] e;
    e = (WORD_W + 1)'(v);
    if (e < 0) begin
      e = -e;
    end
    return DNUM_W'(unsigned'(e));
  endfunction

  function automatic sat_t sat_sum(input hsum_t t);
    return saturate(SAT_W'(t >>> FRAC_BITS));
  endfunction

  function automatic sat_t sat_short(input logic signed [WORD_W:0] v);
    return saturate(SAT_W'(v));
  endfunction

  assign busy   = rst;
  assign accept = start && !busy;

  // Valid bits follow the data down the pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], accept};
    end
  end

  // Squares of both quaternions
  always_ff @(posedge clk) begin
    req1    <= req;
    sq_a[0] <= req.a_w * req.a_w;
    sq_a[1] <= req.a_x * req.a_x;
    sq_a[2] <= req.a_y * req.a_y;
    sq_a[3] <= req.a_z * req.a_z;
    sq_b[0] <= req.b_w * req.b_w;
    sq_b[1] <= req.b_x * req.b_x;
    sq_b[2] <= req.b_y * req.b_y;
    sq_b[3] <= req.b_z * req.b_z;
  end

  // Sums of squares; the divide uses the norm of b, all else that of a
  assign sum_a = SQ_W'(sq_a[0]) + SQ_W'(sq_a[1]) + SQ_W'(sq_a[2]) + SQ_W'(sq_a[3]);
  assign sum_b = SQ_W'(sq_b[0]) + SQ_W'(sq_b[1]) + SQ_W'(sq_b[2]) + SQ_W'(sq_b[3]);
  assign den_sel = (req1.req_type == OP_DIV) ? sum_b : sum_a;

  always_ff @(posedge clk) begin
    sb2.req      <= req1;
    sb2.den_sq   <= den_sel;
    sb2.den_zero <= (den_sel == '0);
    rad_a        <= sum_a;
  end

  // Magnitude of a always goes through the root pipeline
  qau_sqrt u_sqrt (
    .clk  (clk),
    .rad  (rad_a),
    .root (root)
  );

  // Sideband alongside the root stages
  always_ff @(posedge clk) begin
    sb_sq[0] <= sb2;
    for (int i = 1; i < SQRT_STAGES; i++) begin
      sb_sq[i] <= sb_sq[i-1];
    end
  end

  // Divider setup: numerators, signs and denominator per opcode
  always_comb begin
    sb_sq_t s;
    s  = sb_sq[SQRT_STAGES-1];
    av = '{s.req.a_w, s.req.a_x, s.req.a_y, s.req.a_z};
    bv = '{s.req.b_w, s.req.b_x, s.req.b_y, s.req.b_z};
    sb_set_next.req = s.req;
    sb_set_next.mag = root;
    sb_set_next.dz  = s.den_zero && ((s.req.req_type == OP_NORM) ||
                      (s.req.req_type == OP_INV) || (s.req.req_type == OP_DIV));
    if (s.req.req_type == OP_NORM) begin
      den_next = DDEN_W'(root);
    end else begin
      den_next = s.den_sq;
    end
    for (int i = 0; i < 4; i++) begin
      word_t c;
      c = (s.req.req_type == OP_DIV) ? bv[i] : av[i];
      if (s.req.req_type == OP_NORM) begin
        num_next[i]       = abs_word(av[i]) << FRAC_BITS;
        sb_set_next.neg[i] = av[i][WORD_W-1];
      end else begin
        num_next[i] = abs_word(c) << (2 * FRAC_BITS);
        if (i == 0) begin
          sb_set_next.neg[i] = c[WORD_W-1];
        end else begin
          sb_set_next.neg[i] = !c[WORD_W-1] && (c != '0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    sb_set <= sb_set_next;
    den    <= den_next;
    for (int i = 0; i < 4; i++) begin
      num[i] <= num_next[i];
    end
  end

  // Four divider lanes
  for (genvar g = 0; g < 4; g++) begin : g_lane
    qau_div u_div (
      .clk (clk),
      .num (num[g]),
      .den (den),
      .quo (quo[g])
    );
  end

  always_ff @(posedge clk) begin
    sb_dv[0] <= sb_set;
    for (int i = 1; i < DNUM_W; i++) begin
      sb_dv[i] <= sb_dv[i-1];
    end
  end

  // Signed quotients clamped to the word range
  always_comb begin
    sb_dv_t d;
    sat_t   r [4];
    d = sb_dv[DNUM_W-1];
    for (int i = 0; i < 4; i++) begin
      logic signed [SAT_W-1:0] qs;
      qs = SAT_W'({1'b0, quo[i]});
      if (d.neg[i]) begin
        qs = -qs;
      end
      r[i] = saturate(qs);
    end
    sb_s_next.req   = d.req;
    sb_s_next.mag   = d.mag;
    sb_s_next.dz    = d.dz;
    sb_s_next.inv.w = r[0].v;
    sb_s_next.inv.x = r[1].v;
    sb_s_next.inv.y = r[2].v;
    sb_s_next.inv.z = r[3].v;
    sb_s_next.ovf   = r[0].ovf | r[1].ovf | r[2].ovf | r[3].ovf;
  end

  always_ff @(posedge clk) begin
    sb_s <= sb_s_next;
  end

  // Product operand: b for multiply, the scalar for scale, else the inverse
  always_comb begin
    if (sb_s.req.req_type == OP_MUL) begin
      hq = '{sb_s.req.b_w, sb_s.req.b_x, sb_s.req.b_y, sb_s.req.b_z};
    end else if (sb_s.req.req_type == OP_SCALE) begin
      hq = '{sb_s.req.scale_factor, '0, '0, '0};
    end else begin
      hq = sb_s.inv;
    end
  end

  qau_hprod u_hprod (
    .clk (clk),
    .p   ({sb_s.req.a_w, sb_s.req.a_x, sb_s.req.a_y, sb_s.req.a_z}),
    .q   (hq),
    .t   (ht)
  );

  always_ff @(posedge clk) begin
    sb_h1 <= sb_s;
    sb_h2 <= sb_h1;
  end

  // Result select and status
  always_comb begin
    sat_t r [4];
    logic ovf;
    req_t q;
    q   = sb_h2.req;
    ovf = 1'b0;
    for (int i = 0; i < 4; i++) begin
      r[i] = '0;
    end
    unique case (q.req_type)
      OP_ADD: begin
        r[0] = sat_short((WORD_W + 1)'(q.a_w) + (WORD_W + 1)'(q.b_w));
        r[1] = sat_short((WORD_W + 1)'(q.a_x) + (WORD_W + 1)'(q.b_x));
        r[2] = sat_short((WORD_W + 1)'(q.a_y) + (WORD_W + 1)'(q.b_y));
        r[3] = sat_short((WORD_W + 1)'(q.a_z) + (WORD_W + 1)'(q.b_z));
      end
      OP_SUB: begin
        r[0] = sat_short((WORD_W + 1)'(q.a_w) - (WORD_W + 1)'(q.b_w));
        r[1] = sat_short((WORD_W + 1)'(q.a_x) - (WORD_W + 1)'(q.b_x));
        r[2] = sat_short((WORD_W + 1)'(q.a_y) - (WORD_W + 1)'(q.b_y));
        r[3] = sat_short((WORD_W + 1)'(q.a_z) - (WORD_W + 1)'(q.b_z));
      end
      OP_MUL, OP_SCALE, OP_DIV: begin
        r[0] = sat_sum(ht.w);
        r[1] = sat_sum(ht.x);
        r[2] = sat_sum(ht.y);
        r[3] = sat_sum(ht.z);
        ovf  = (q.req_type == OP_DIV) && sb_h2.ovf;
      end
      OP_CONJ: begin
        r[0] = sat_short((WORD_W + 1)'(q.a_w));
        r[1] = sat_short(-(WORD_W + 1)'(q.a_x));
        r[2] = sat_short(-(WORD_W + 1)'(q.a_y));
        r[3] = sat_short(-(WORD_W + 1)'(q.a_z));
      end
      OP_NORM, OP_INV: begin
        r[0] = '{sb_h2.inv.w, 1'b0};
        r[1] = '{sb_h2.inv.x, 1'b0};
        r[2] = '{sb_h2.inv.y, 1'b0};
        r[3] = '{sb_h2.inv.z, 1'b0};
        ovf  = sb_h2.ovf;
      end
      default: begin
        ovf = 1'b0;
      end
    endcase
    ovf = ovf | r[0].ovf | r[1].ovf | r[2].ovf | r[3].ovf;
    res_next.norm_value = sb_h2.mag;
    if (sb_h2.dz) begin
      res_next.res_w  = '0;
      res_next.res_x  = '0;
      res_next.res_y  = '0;
      res_next.res_z  = '0;
      res_next.status = ST_DZ;
    end else begin
      res_next.res_w  = r[0].v;
      res_next.res_x  = r[1].v;
      res_next.res_y  = r[2].v;
      res_next.res_z  = r[3].v;
      res_next.status = ovf ? ST_OVF : ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  assign done = vld[LATENCY-1];

  // A result only comes from a transfer that has passed through the whole pipeline
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without matching request");

  // Zero-norm status carries zero components
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    done && (res.status == ST_DZ) |->
      (res.res_w == '0) && (res.res_x == '0) && (res.res_y == '0) && (res.res_z == '0))
    else $error("nonzero components with zero-norm status");

  // Status codes stay in range
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> (res.status == ST_OK) || (res.status == ST_DZ) || (res.status == ST_OVF))
    else $error("bad status code");

endmodule
`default_nettype wire

[sv/qau_sqrt.sv]
`default_nettype none
module qau_sqrt (
  input  wire                        clk,
  input  wire [qau_pkg::SQ_W-1:0]    rad,
  output logic [qau_pkg::NORM_W-1:0] root
);
  import qau_pkg::*;

  logic [RAD_W-1:0]  rad_q  [SQRT_STAGES];
  logic [REM_W-1:0]  rem_q  [SQRT_STAGES];
  logic [NORM_W-1:0] root_q [SQRT_STAGES];

  // Digit-by-digit root, two radicand bits per stage
  for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_stage
    logic [RAD_W-1:0]  rad_i;
    logic [REM_W-1:0]  rem_i;
    logic [NORM_W-1:0] root_i;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;

    if (g == 0) begin : g_first
      assign rad_i  = RAD_W'(rad);
      assign rem_i  = '0;
      assign root_i = '0;
    end else begin : g_next
      assign rad_i  = rad_q[g-1];
      assign rem_i  = rem_q[g-1];
      assign root_i = root_q[g-1];
    end

    assign rem_sh = {rem_i[REM_W-3:0], rad_i[RAD_W-1 -: 2]};
    assign trial  = REM_W'({root_i, 2'b01});

    always_ff @(posedge clk) begin
      rad_q[g] <= {rad_i[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q[g]  <= rem_sh - trial;
        root_q[g] <= {root_i[NORM_W-2:0], 1'b1};
      end else begin
        rem_q[g]  <= rem_sh;
        root_q[g] <= {root_i[NORM_W-2:0], 1'b0};
      end
    end
  end

  assign root = root_q[SQRT_STAGES-1];

endmodule
`default_nettype wire

[sv/qau_div.sv]
`default_nettype none
module qau_div (
  input  wire                        clk,
  input  wire [qau_pkg::DNUM_W-1:0]  num,
  input  wire [qau_pkg::DDEN_W-1:0]  den,
  output logic [qau_pkg::DNUM_W-1:0] quo
);
  import qau_pkg::*;

  // Numerator shifts out the top while quotient bits shift in below
  logic [DNUM_W-1:0] nq_q  [DNUM_W];
  logic [DREM_W-1:0] rem_q [DNUM_W];
  logic [DDEN_W-1:0] den_q [DNUM_W];

  // Restoring division, one quotient bit per stage
  for (genvar g = 0; g < DNUM_W; g++) begin : g_stage
    logic [DNUM_W-1:0] nq_i;
    logic [DREM_W-1:0] rem_i;
    logic [DDEN_W-1:0] den_i;
    logic [DREM_W-1:0] rem_sh;

    if (g == 0) begin : g_first
      assign nq_i  = num;
      assign rem_i = '0;
      assign den_i = den;
    end else begin : g_next
      assign nq_i  = nq_q[g-1];
      assign rem_i = rem_q[g-1];
      assign den_i = den_q[g-1];
    end

    assign rem_sh = {rem_i[DREM_W-2:0], nq_i[DNUM_W-1]};

    always_ff @(posedge clk) begin
      den_q[g] <= den_i;
      if (rem_sh >= DREM_W'(den_i)) begin
        rem_q[g] <= rem_sh - DREM_W'(den_i);
        nq_q[g]  <= {nq_i[DNUM_W-2:0], 1'b1};
      end else begin
        rem_q[g] <= rem_sh;
        nq_q[g]  <= {nq_i[DNUM_W-2:0], 1'b0};
      end
    end
  end

  assign quo = nq_q[DNUM_W-1];

endmodule
`default_nettype wire

[sv/qau_hprod.sv]
`default_nettype none
module qau_hprod (
  input  wire                   clk,
  input  wire qau_pkg::quat_t   p,
  input  wire qau_pkg::quat_t   q,
  output qau_pkg::hquat_t       t
);
  import qau_pkg::*;

  logic signed [PROD_W-1:0] pr [16];

  // Stage 1: sixteen partial products
  always_ff @(posedge clk) begin
    pr[0]  <= p.w * q.w;
    pr[1]  <= p.x * q.x;
    pr[2]  <= p.y * q.y;
    pr[3]  <= p.z * q.z;
    pr[4]  <= p.w * q.x;
    pr[5]  <= p.x * q.w;
    pr[6]  <= p.y * q.z;
    pr[7]  <= p.z * q.y;
    pr[8]  <= p.w * q.y;
    pr[9]  <= p.x * q.z;
    pr[10] <= p.y * q.w;
    pr[11] <= p.z * q.x;
    pr[12] <= p.w * q.z;
    pr[13] <= p.x * q.y;
    pr[14] <= p.y * q.x;
    pr[15] <= p.z * q.w;
  end

  // Stage 2: exact component sums
  always_ff @(posedge clk) begin
    t.w <= HSUM_W'(pr[0]) - HSUM_W'(pr[1]) - HSUM_W'(pr[2]) - HSUM_W'(pr[3]);
    t.x <= HSUM_W'(pr[4]) + HSUM_W'(pr[5]) + HSUM_W'(pr[6]) - HSUM_W'(pr[7]);
    t.y <= HSUM_W'(pr[8]) - HSUM_W'(pr[9]) + HSUM_W'(pr[10]) + HSUM_W'(pr[11]);
    t.z <= HSUM_W'(pr[12]) + HSUM_W'(pr[13]) - HSUM_W'(pr[14]) + HSUM_W'(pr[15]);
  end

endmodule
`default_nettype wire

[verif/tb.sv]
`default_nettype none
module tb;
  import qau_pkg::*;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t req;
  logic done;
  res_t res;

  quaternion_arithmetic_unit u_top (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .req  (req),
    .done (done),
    .res  (res)
  );

  typedef logic signed [127:0] wide_t;

  req_t pending_reqs[$];
  res_t expected_results[$];
  int   n_errors;
  bit   stim_done;
  bit   drv_quiet;

  // Clamp to word range, flag overflow
  function automatic word_t clamp_word(input wide_t v, inout bit ovf);
    wide_t hi;
    wide_t lo;
    hi = 128'sh7fffffff;
    lo = -128'sh80000000;
    if (v > hi) begin
      ovf = 1'b1;
      return word_t'(32'h7fffffff);
    end else if (v < lo) begin
      ovf = 1'b1;
      return word_t'(32'h80000000);
    end
    return word_t'(v[31:0]);
  endfunction

  function automatic wide_t wsq(input word_t v);
    wide_t t;
    t = wide_t'(v);
    return t * t;
  endfunction

  function automatic wide_t sum_squares(input word_t q[4]);
    return wsq(q[0]) + wsq(q[1]) + wsq(q[2]) + wsq(q[3]);
  endfunction

  // Floor square root, bit by bit
  function automatic logic [63:0] floor_sqrt(input wide_t n);
    logic [63:0] r;
    logic [63:0] c;
    wide_t cc;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      cc = wide_t'({64'd0, c}) * wide_t'({64'd0, c});
      if ($unsigned(n) >= $unsigned(cc)) r = c;
    end
    return r;
  endfunction

  // Truncating signed divide by positive denominator
  function automatic wide_t trunc_div(input wide_t n, input wide_t d);
    wide_t q;
    if (n < 0) begin
      q = (-n) / d;
      return -q;
    end
    return n / d;
  endfunction

  function automatic wide_t sx(input word_t v);
    return wide_t'(v);
  endfunction

  // Hamilton product with floor shift and saturation
  function automatic void hamilton(input word_t p[4], input word_t q[4],
                                   output word_t r[4], inout bit ovf);
    wide_t t[4];
    t[0] = sx(p[0])*sx(q[0]) - sx(p[1])*sx(q[1]) - sx(p[2])*sx(q[2]) - sx(p[3])*sx(q[3]);
    t[1] = sx(p[0])*sx(q[1]) + sx(p[1])*sx(q[0]) + sx(p[2])*sx(q[3]) - sx(p[3])*sx(q[2]);
    t[2] = sx(p[0])*sx(q[2]) - sx(p[1])*sx(q[3]) + sx(p[2])*sx(q[0]) + sx(p[3])*sx(q[1]);
    t[3] = sx(p[0])*sx(q[3]) + sx(p[1])*sx(q[2]) - sx(p[2])*sx(q[1]) + sx(p[3])*sx(q[0]);
    for (int i = 0; i < 4; i++) r[i] = clamp_word(t[i] >>> FRAC_BITS, ovf);
  endfunction

  // Conjugate over squared norm; returns 0 for zero norm
  function automatic bit quat_inverse(input word_t p[4], output word_t r[4],
                                      inout bit ovf);
    wide_t s;
    wide_t c;
    s = sum_squares(p);
    for (int i = 0; i < 4; i++) r[i] = '0;
    if (s == 0) return 1'b0;
    for (int i = 0; i < 4; i++) begin
      c = (i == 0) ? sx(p[0]) : -sx(p[i]);
      r[i] = clamp_word(trunc_div(c <<< (2 * FRAC_BITS), s), ovf);
    end
    return 1'b1;
  endfunction

  function automatic res_t predict_result(input req_t q);
    word_t a[4];
    word_t b[4];
    word_t r[4];
    word_t inv[4];
    logic [63:0] mag;
    bit ovf;
    bit dz;
    res_t o;
    a = '{q.a_w, q.a_x, q.a_y, q.a_z};
    b = '{q.b_w, q.b_x, q.b_y, q.b_z};
    r = '{default: '0};
    ovf = 0;
    dz = 0;
    mag = floor_sqrt(sum_squares(a));
    case (q.req_type)
      OP_ADD: for (int i = 0; i < 4; i++) r[i] = clamp_word(sx(a[i]) + sx(b[i]), ovf);
      OP_SUB: for (int i = 0; i < 4; i++) r[i] = clamp_word(sx(a[i]) - sx(b[i]), ovf);
      OP_MUL: hamilton(a, b, r, ovf);
      OP_SCALE: begin
        for (int i = 0; i < 4; i++)
          r[i] = clamp_word((sx(q.scale_factor) * sx(a[i])) >>> FRAC_BITS, ovf);
      end
      OP_CONJ: begin
        r[0] = a[0];
        for (int i = 1; i < 4; i++) r[i] = clamp_word(-sx(a[i]), ovf);
      end
      OP_NORM: begin
        if (mag == 0) dz = 1;
        else begin
          for (int i = 0; i < 4; i++)
            r[i] = clamp_word(trunc_div(sx(a[i]) <<< FRAC_BITS,
                                        wide_t'({64'd0, mag})), ovf);
        end
      end
      OP_INV: if (!quat_inverse(a, r, ovf)) dz = 1;
      OP_DIV: begin
        if (!quat_inverse(b, inv, ovf)) dz = 1;
        else hamilton(a, inv, r, ovf);
      end
      default: ;
    endcase
    if (dz) begin
      r = '{default: '0};
      ovf = 0;
    end
    o.res_w = r[0];
    o.res_x = r[1];
    o.res_y = r[2];
    o.res_z = r[3];
    o.norm_value = mag[NORM_W-1:0];
    o.status = dz ? ST_DZ : (ovf ? ST_OVF : ST_OK);
    return o;
  endfunction

  // Random component: mostly moderate, sometimes full range or extreme
  function automatic word_t rand_comp();
    case ($urandom_range(0, 9))
      0: return word_t'($urandom);
      1: return word_t'(32'h80000000);
      2: return word_t'(32'h7fffffff);
      3: return '0;
      4, 5: return word_t'($signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff);
      default: return word_t'($signed($urandom_range(0, 32'h7ffffff)) - 32'sh3ffffff);
    endcase
  endfunction

  function automatic req_t rand_req();
    req_t q;
    q.req_type = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
                                               : 4'($urandom_range(0, 8));
    q.a_w = rand_comp();
    q.a_x = rand_comp();
    q.a_y = rand_comp();
    q.a_z = rand_comp();
    q.b_w = rand_comp();
    q.b_x = rand_comp();
    q.b_y = rand_comp();
    q.b_z = rand_comp();
    q.scale_factor = rand_comp();
    // zero quaternions now and then to hit zero norm
    if ($urandom_range(0, 15) == 0) {q.a_w, q.a_x, q.a_y, q.a_z} = '0;
    if ($urandom_range(0, 15) == 0) {q.b_w, q.b_x, q.b_y, q.b_z} = '0;
    return q;
  endfunction

  function automatic req_t mk_req(input logic [3:0] op, input word_t av, input word_t bv,
                                  input word_t k);
    req_t q;
    q.req_type = op;
    q.a_w = av; q.a_x = av; q.a_y = av; q.a_z = av;
    q.b_w = bv; q.b_x = bv; q.b_y = bv; q.b_z = bv;
    q.scale_factor = k;
    return q;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Stimulus
  initial begin
    word_t one;
    word_t mn;
    word_t mx;
    req_t q;
    one = 32'sh10000;
    mn = word_t'(32'h80000000);
    mx = word_t'(32'h7fffffff);
    rst = 1;
    stim_done = 0;
    n_errors = 0;
    for (int op = 0; op <= 8; op++)
      pending_reqs.push_back(mk_req(4'(op), one, 32'sh20000, 32'sh18000));
    pending_reqs.push_back(mk_req(OP_ADD, mx, mx, one));
    pending_reqs.push_back(mk_req(OP_SUB, mn, mx, one));
    pending_reqs.push_back(mk_req(OP_MUL, mn, mn, one));
    pending_reqs.push_back(mk_req(OP_SCALE, mx, one, mn));
    pending_reqs.push_back(mk_req(OP_CONJ, mn, '0, '0));
    pending_reqs.push_back(mk_req(OP_MAG, mn, '0, '0));
    pending_reqs.push_back(mk_req(OP_NORM, '0, one, one));
    pending_reqs.push_back(mk_req(OP_INV, '0, one, one));
    pending_reqs.push_back(mk_req(OP_DIV, one, '0, one));
    pending_reqs.push_back(mk_req(OP_INV, 32'sh1, '0, '0));
    pending_reqs.push_back(mk_req(OP_DIV, mx, 32'sh1, '0));
    pending_reqs.push_back(mk_req(OP_NORM, mn, '0, '0));
    pending_reqs.push_back(mk_req(4'd15, mx, mn, mx));
    pending_reqs.push_back(mk_req(4'd9, -32'sd1, -32'sd1, -32'sd1));
    for (int i = 0; i < 1500; i++) pending_reqs.push_back(rand_req());
    repeat (6) @(posedge clk);
    @(negedge clk) rst = 0;
    stim_done = 1;
  end

  // Driver: changes at falling edge, transfer on rising edge with busy low
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
      req <= '0;
      drv_quiet <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(predict_result(req));
        void'(pending_reqs.pop_front());
      end
      if (pending_reqs.size() > 0 && (drv_quiet || $urandom_range(0, 99) >= 12)) begin
        start <= 1'b1;
        req <= pending_reqs[0];
      end else begin
        start <= 1'b0;
      end
      // long stretch with no gaps in the middle of the run
      drv_quiet <= (pending_reqs.size() > 600 && pending_reqs.size() < 900);
    end
  end

  // Monitor
  always @(posedge clk) begin
    res_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, res);
        n_errors++;
      end else begin
        e = expected_results.pop_front();
        if (res.res_w !== e.res_w)
          $display("%0t: res_w expected %h actual %h", $time, e.res_w, res.res_w);
        if (res.res_x !== e.res_x)
          $display("%0t: res_x expected %h actual %h", $time, e.res_x, res.res_x);
        if (res.res_y !== e.res_y)
          $display("%0t: res_y expected %h actual %h", $time, e.res_y, res.res_y);
        if (res.res_z !== e.res_z)
          $display("%0t: res_z expected %h actual %h", $time, e.res_z, res.res_z);
        if (res.norm_value !== e.norm_value)
          $display("%0t: norm_value expected %h actual %h", $time, e.norm_value,
                   res.norm_value);
        if (res.status !== e.status)
          $display("%0t: status expected %0d actual %0d", $time, e.status, res.status);
        if (res !== e) n_errors++;
      end
    end
  end

  // End of run
  initial begin
    wait (stim_done);
    wait (pending_reqs.size() == 0 && expected_results.size() == 0 && !start);
    repeat (LATENCY + 20) @(posedge clk);
    if (n_errors == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

  initial begin
    #400000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
